FILE: hdl/triggered_block_averager_defines.svh
// Assertion macros shared by the averager RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef TRIGGERED_BLOCK_AVERAGER_DEFINES_SVH
`define TRIGGERED_BLOCK_AVERAGER_DEFINES_SVH

// same-cycle implication
`define TBA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TBA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tba_pkg.sv
// Shared types and constants of the triggered block averager.
// No dependencies; imported by tba_accum and triggered_block_averager.
package tba_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int ACC_W      = 40;
	localparam int LEN_W      = 10;
	localparam int LOG2_W     = 3;
	localparam int BLK_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int SEQ_DEPTH_DEF         = 1024;
	localparam int PACKET_LAST_INDEX_DEF = 259;

	localparam logic [LEN_W-1:0] SEQ_LEN_RESET = LEN_W'(1023);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_THRESHOLD = 2'd0,
		REG_SEQUENCE_LENGTH   = 2'd1,
		REG_LOG2_BLOCK_COUNT  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              emit;
		logic              use_acc;
		logic              last;
		logic [LOG2_W-1:0] shift;
	} op_ctrl_t;

endpackage

FILE: hdl/tba_accum.sv
// Accumulator memory with its read-modify-write stage and forwarding.
// Depends on tba_pkg and triggered_block_averager_defines.svh.
`include "triggered_block_averager_defines.svh"

module tba_accum #(
	parameter int SEQ_DEPTH = tba_pkg::SEQ_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  tba_pkg::op_ctrl_t                   in_ctrl,
	input  logic [$clog2(SEQ_DEPTH)-1:0]        in_addr,
	input  logic [tba_pkg::SAMPLE_W-1:0]        in_sample,
	output logic                                in_ready,
	input  logic                                out_ready,
	output logic                                res_valid,
	output logic [tba_pkg::SAMPLE_W-1:0]        res_average,
	output logic                                res_last
);
	import tba_pkg::*;

	localparam int AW = $clog2(SEQ_DEPTH);

	logic [ACC_W-1:0]    mem [SEQ_DEPTH];
	logic [ACC_W-1:0]    rd_q;
	logic                fwd_q;
	logic [ACC_W-1:0]    fwd_data_q;
	logic                s1_valid_q;
	op_ctrl_t            s1_ctrl_q;
	logic [AW-1:0]       s1_addr_q;
	logic [SAMPLE_W-1:0] s1_sample_q;

	logic             s1_adv;
	logic             wr;
	logic [ACC_W-1:0] opnd;
	logic [ACC_W-1:0] sum;

	assign s1_adv   = s1_valid_q && (!s1_ctrl_q.emit || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign wr       = s1_adv && !s1_ctrl_q.emit;
	assign opnd     = fwd_q ? fwd_data_q : rd_q;
	assign sum      = (s1_ctrl_q.use_acc ? opnd : '0) + ACC_W'(s1_sample_q);

	assign res_valid   = s1_valid_q && s1_ctrl_q.emit;
	assign res_average = SAMPLE_W'(sum >> s1_ctrl_q.shift);
	assign res_last    = s1_ctrl_q.last;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[s1_addr_q] <= sum;
		end
		if (in_valid) begin
			rd_q        <= mem[in_addr];
			fwd_q       <= wr && (s1_addr_q == in_addr);
			fwd_data_q  <= sum;
			s1_ctrl_q   <= in_ctrl;
			s1_addr_q   <= in_addr;
			s1_sample_q <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	`TBA_ASSERT_NOW(a_enter_when_ready, clk, arst_n, in_valid, in_ready, "word entered a full stage")
	`TBA_ASSERT_NEXT(a_stall_holds, clk, arst_n, s1_valid_q && !s1_adv,
		s1_valid_q && $stable(s1_addr_q) && $stable(s1_sample_q), "stalled stage changed")
	`TBA_ASSERT_NOW(a_no_write_on_emit, clk, arst_n, res_valid, !wr, "memory written on output")

endmodule

FILE: hdl/triggered_block_averager.sv
// Triggered block averager: one sample word per cycle, stalling only while the output register
// is full and held. Each triggered word is read from memory and, unless it emits, rewritten.
// A result word is registered in the stage register (read, add), then in the output register.
// Reset clears all control state and config registers; the accumulator memory is not cleared
// and needs no clearing pass, since the first sequence of every frame writes each entry first.
// Depends on tba_pkg, tba_accum and triggered_block_averager_defines.svh.
`include "triggered_block_averager_defines.svh"

module triggered_block_averager #(
	parameter int SEQ_DEPTH         = tba_pkg::SEQ_DEPTH_DEF,
	parameter int PACKET_LAST_INDEX = tba_pkg::PACKET_LAST_INDEX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tba_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tba_pkg::SAMPLE_W-1:0]       m_tdata,   // [31:0] average
	output logic                               m_tlast,
	input  logic                               cfg_wr_en,
	input  logic [tba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tba_pkg::*;

	localparam int AW    = $clog2(SEQ_DEPTH);
	localparam int PKT_W = $clog2(PACKET_LAST_INDEX + 1);

	logic [SAMPLE_W-1:0] thr_q;
	logic [LEN_W-1:0]    seq_len_q;
	logic [LOG2_W-1:0]   log2_q;

	logic                triggered_q;
	logic [AW-1:0]       last_pos_q;
	logic [LOG2_W-1:0]   k_q;
	logic [AW-1:0]       wpos_q;
	logic [BLK_W-1:0]    blk_q;
	logic [PKT_W-1:0]    pkt_q;

	logic [AW-1:0]       cfg_last_pos;
	logic [AW-1:0]       cur_last_pos;
	logic [LOG2_W-1:0]   cur_k;
	logic [BLK_W-1:0]    blk_final;
	logic                accept;
	logic                go;
	logic                seq_end;
	logic                emit;
	op_ctrl_t            ctrl;

	logic                acc_ready;
	logic                res_valid;
	logic [SAMPLE_W-1:0] res_average;
	logic                res_last;
	logic                out_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			seq_len_q <= SEQ_LEN_RESET;
			log2_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TRIGGER_THRESHOLD: thr_q     <= cfg_wdata[SAMPLE_W-1:0];
				REG_SEQUENCE_LENGTH:   seq_len_q <= cfg_wdata[LEN_W-1:0];
				REG_LOG2_BLOCK_COUNT:  log2_q    <= cfg_wdata[LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (seq_len_q == '0) begin
			cfg_last_pos = '0;
		end else if (32'(seq_len_q) > 32'(SEQ_DEPTH)) begin
			cfg_last_pos = AW'(SEQ_DEPTH - 1);
		end else begin
			cfg_last_pos = AW'(32'(seq_len_q) - 32'd1);
		end
	end

	assign cur_last_pos = triggered_q ? last_pos_q : cfg_last_pos;
	assign cur_k        = triggered_q ? k_q : log2_q;
	assign blk_final    = BLK_W'((32'd1 << cur_k) - 32'd1);
	assign accept       = s_tvalid && s_tready;
	assign go           = triggered_q || (s_tdata > thr_q);
	assign seq_end      = (wpos_q == cur_last_pos);
	assign emit         = (blk_q == blk_final);

	assign ctrl.emit    = emit;
	assign ctrl.use_acc = (blk_q != '0);
	assign ctrl.last    = seq_end || (pkt_q == PKT_W'(PACKET_LAST_INDEX));
	assign ctrl.shift   = cur_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triggered_q <= 1'b0;
			last_pos_q  <= '0;
			k_q         <= '0;
			wpos_q      <= '0;
			blk_q       <= '0;
			pkt_q       <= '0;
		end else if (accept) begin
			if (!triggered_q) begin
				last_pos_q <= cfg_last_pos;
				k_q        <= log2_q;
			end
			if (go) begin
				triggered_q <= 1'b1;
				if (seq_end) begin
					wpos_q <= '0;
					blk_q  <= emit ? '0 : blk_q + 1'b1;
				end else begin
					wpos_q <= wpos_q + 1'b1;
				end
				if (emit) begin
					pkt_q <= ctrl.last ? '0 : pkt_q + 1'b1;
				end
			end
		end
	end

	tba_accum #(
		.SEQ_DEPTH(SEQ_DEPTH)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept && go),
		.in_ctrl    (ctrl),
		.in_addr    (wpos_q),
		.in_sample  (s_tdata),
		.in_ready   (acc_ready),
		.out_ready  (out_room),
		.res_valid  (res_valid),
		.res_average(res_average),
		.res_last   (res_last)
	);

	assign s_tready = acc_ready;
	assign out_room = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_room) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_room && res_valid) begin
			m_tdata <= res_average;
			m_tlast <= res_last;
		end
	end

	`TBA_ASSERT_NOW(a_idle_counters, clk, arst_n, !triggered_q,
		(wpos_q == '0) && (blk_q == '0), "counters moved before trigger")
	`TBA_ASSERT_NOW(a_pos_in_range, clk, arst_n, triggered_q, wpos_q <= last_pos_q,
		"write position past sequence end")
	`TBA_ASSERT_NOW(a_blk_in_range, clk, arst_n, triggered_q, blk_q <= blk_final,
		"block index past final block")

endmodule

FILE: tb/sv/tb_triggered_block_averager.sv
// Self-checking bench for triggered_block_averager: sample words in, averaged words out.
// Predicts each average in-bench from the register settings, with bursty input and stalled output.
// Depends on tba_pkg and the triggered_block_averager RTL.
module tb_triggered_block_averager;
	import tba_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_LATER} avg_phase_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic                last;
	} avg_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [SAMPLE_W-1:0]  m_tdata;
	logic                 m_tlast;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// register copies and averager state
	logic [SAMPLE_W-1:0] thr_reg;
	logic [LEN_W-1:0]    len_reg;
	logic [LOG2_W-1:0]   log2_reg;
	avg_phase_t          phase;
	logic                armed;
	logic [LEN_W-1:0]    lat_len;
	logic [LOG2_W-1:0]   lat_log2;
	logic [LEN_W-1:0]    wr_pos;
	logic [7:0]          blk;
	logic [LEN_W-1:0]    out_pos;
	logic [8:0]          pkt_cnt;
	logic [ACC_W-1:0]    acc_mem [0:SEQ_DEPTH_DEF-1];

	avg_word_t pending_averages[$];
	avg_word_t want;

	int  samples_sent;
	int  averages_seen;
	int  marks_seen;
	int  mismatch_count;
	int  burst_left;
	int  stall_requests;
	bit  idling_on;

	triggered_block_averager DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

	task automatic predict_average(input logic [SAMPLE_W-1:0] s);
		int         len;
		int         pos;
		int         k;
		int         final_blk;
		logic [ACC_W-1:0] sum;
		bit         seq_end;
		bit         emitted;
		avg_word_t  w;
		emitted = 0;
		if (phase == PH_IDLE) begin
			if (!armed) begin
				lat_len = len_reg;
				lat_log2 = log2_reg;
				if (s > thr_reg)
					armed = 1'b1;
			end
			if (!armed)
				return;
			wr_pos = '0;
			blk = '0;
			phase = PH_FIRST;
		end
		len = (lat_len == 0) ? 1 : int'(lat_len);
		if (len > SEQ_DEPTH_DEF)
			len = SEQ_DEPTH_DEF;
		pos = int'(wr_pos) % SEQ_DEPTH_DEF;
		k = int'(lat_log2);
		final_blk = (1 << k) - 1;
		if (int'(blk) >= final_blk) begin
			sum = {8'h00, s};
			if (blk != 0)
				sum = sum + acc_mem[pos];
			seq_end = (int'(out_pos) + 1 >= len);
			w.last = seq_end || (int'(pkt_cnt) == PACKET_LAST_INDEX_DEF);
			pkt_cnt = w.last ? 9'd0 : pkt_cnt + 9'd1;
			out_pos = seq_end ? '0 : out_pos + 1'b1;
			w.average = SAMPLE_W'(sum >> k);
			pending_averages.push_back(w);
			emitted = 1;
		end else if (blk == 0) begin
			acc_mem[pos] = {8'h00, s};
		end else begin
			acc_mem[pos] = acc_mem[pos] + {8'h00, s};
		end
		if (pos + 1 >= len) begin
			wr_pos = '0;
			if (emitted) begin
				blk = '0;
				phase = PH_IDLE;
			end else begin
				blk = blk + 8'd1;
				phase = PH_LATER;
			end
		end else begin
			wr_pos = LEN_W'(pos + 1);
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		predict_average(value);
		samples_sent++;
		if (idling_on) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
			end
		end
	endtask

	task automatic wait_for_averages();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_averages.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_TRIGGER_THRESHOLD: thr_reg = value;
			REG_SEQUENCE_LENGTH:   len_reg = value[LEN_W-1:0];
			REG_LOG2_BLOCK_COUNT:  log2_reg = value[LOG2_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_quiet_samples();
		write_register(REG_TRIGGER_THRESHOLD, '1);
		write_register(REG_SEQUENCE_LENGTH, 32'd1);
		write_register(REG_LOG2_BLOCK_COUNT, 32'd7);
		send_sample('0);
		send_sample('1);
		send_sample($urandom);
		wait_for_averages();
		write_register(REG_TRIGGER_THRESHOLD, '0);
		write_register(REG_SEQUENCE_LENGTH, 32'd1023);
		write_register(REG_LOG2_BLOCK_COUNT, 32'd0);
		send_sample('0);
		wait_for_averages();
	endtask

	task automatic test_trigger_and_extremes();
		logic [SAMPLE_W-1:0] thr;
		thr = $urandom_range(1, 32'hFFFF_FFFE);
		write_register(REG_TRIGGER_THRESHOLD, thr);
		write_register(REG_SEQUENCE_LENGTH, $urandom_range(261, 300));
		write_register(REG_LOG2_BLOCK_COUNT, $urandom_range(0, 1));
		send_sample(thr);
		send_sample(thr + 1'b1);
		for (int i = 0; i < 16; i++) begin
			case (i % 4)
				0: send_sample('0);
				1: send_sample('1);
				2: send_sample(32'h5555_5555);
				default: send_sample(32'hAAAA_AAAA);
			endcase
		end
	endtask

	task automatic test_random_stream(input int count);
		repeat (count) send_sample(random_sample());
	endtask

	task automatic test_output_backpressure();
		// advance to the sequence that emits so the output register fills
		while (!((phase != PH_IDLE && blk >= (8'd1 << lat_log2) - 8'd1) ||
				(phase == PH_IDLE && lat_log2 == 0)))
			send_sample(random_sample());
		stall_requests++;
		repeat (40) send_sample(random_sample());
	endtask

	task automatic test_writes_after_trigger();
		wait_for_averages();
		write_register(REG_TRIGGER_THRESHOLD, '0);
		write_register(REG_SEQUENCE_LENGTH, 32'd1);
		write_register(REG_LOG2_BLOCK_COUNT, 32'd7);
		repeat (100) send_sample(random_sample());
	endtask

	task automatic test_unbroken_stream();
		idling_on = 1'b0;
		repeat (150) send_sample(random_sample());
		idling_on = 1'b1;
	endtask

	// receiver: random ready pattern, always ready while idling is off, plus long hold-offs on request
	initial begin
		int          stall_served;
		int          stall_left;
		int          pat_step;
		logic [15:0] stall_pattern;
		stall_served = 0;
		stall_left = 0;
		pat_step = 0;
		stall_pattern = '1;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_requests != stall_served) begin
				stall_served = stall_requests;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!idling_on) begin
				m_tready <= 1'b1;
			end else begin
				if (pat_step == 0) begin
					stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
					pat_step = 16;
				end
				m_tready <= stall_pattern[pat_step-1];
				pat_step--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			averages_seen++;
			if (m_tlast)
				marks_seen++;
			if (pending_averages.size() == 0) begin
				$error("unexpected output word: average %h last %b", m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				want = pending_averages.pop_front();
				if (m_tdata !== want.average) begin
					$error("average: expected %h, got %h", want.average, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TRIGGER_THRESHOLD;
		cfg_wdata = '0;
		thr_reg = '0;
		len_reg = SEQ_LEN_RESET;
		log2_reg = '0;
		phase = PH_IDLE;
		armed = 1'b0;
		lat_len = '0;
		lat_log2 = '0;
		wr_pos = '0;
		blk = '0;
		out_pos = '0;
		pkt_cnt = '0;
		samples_sent = 0;
		averages_seen = 0;
		marks_seen = 0;
		mismatch_count = 0;
		burst_left = 4;
		stall_requests = 0;
		idling_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_quiet_samples();
		test_trigger_and_extremes();
		test_random_stream(180);
		test_output_backpressure();
		test_writes_after_trigger();
		test_unbroken_stream();

		wait_for_averages();
		repeat (8) @(posedge clk);
		if (pending_averages.size() != 0) begin
			$error("%0d averages never arrived", pending_averages.size());
			mismatch_count++;
		end
		$display("Sent %0d samples, checked %0d averages (%0d marked last).",
			samples_sent, averages_seen, marks_seen);
		$display("Frames used length %0d and log2 block count %0d after the trigger.",
			lat_len, lat_log2);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
